// ----- src/mcd_pkg.sv -----
`timescale 1ns / 1ps

package mcd_pkg;

  // event kinds
  typedef enum logic [1:0] {
    OP_PRESS  = 2'd0,
    OP_MOTION = 2'd1,
    OP_TICK   = 2'd2
  } mcd_op_e;

  // register indexes on the config port
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_WINDOW    = 1'b1;

  // register reset values
  localparam logic [7:0]  TOLERANCE_RESET = 8'd3;
  localparam logic [15:0] WINDOW_RESET    = 16'd250;

  localparam logic [7:0] CLICKS_MAX = 8'hFF;

  // one pointer event as held in the input register
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] elapsed_ms;
  } mcd_event_t;

  // one result beat
  typedef struct packed {
    logic       fired;
    logic [7:0] click_count;
  } mcd_result_t;

endpackage

// ----- src/multi_click_detector.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in       input      in_valid_i/in_stall_o    operation, pos_x, pos_y, elapsed_ms
// out      output     out_valid_o/out_stall_i  fired, click_count
// cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// one event per cycle while in_stall_o is low; a result passes through the input
// register, then the result register, and is set by the single state update.
// reset clears the sequence state and loads tolerance 3, window 250.
// a stalled result holds; the input register still drains into an empty
// result register, so input is stalled only when both registers are full
// and the result is stalled.
// cfg_ready_o is always high.

module multi_click_detector import mcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        fired_o,
  output logic [7:0]  click_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0]  tolerance_q;
  logic [15:0] window_q;

  logic        ev_valid_q;
  mcd_event_t  ev_q;
  logic        res_valid_q;
  mcd_result_t res_q;
  mcd_result_t res_d;
  logic        advance;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= TOLERANCE_RESET;
      window_q    <= WINDOW_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TOLERANCE: tolerance_q <= cfg_data_i[7:0];
        CFG_WINDOW:    window_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  assign advance    = ev_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = ev_valid_q && res_valid_q && out_stall_i;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      ev_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ev_q <= '{op: operation_i, pos_x: pos_x_i, pos_y: pos_y_i,
                elapsed_ms: elapsed_ms_i};
    end
  end

  mcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .event_i     (ev_q),
    .tolerance_i (tolerance_q),
    .window_i    (window_q),
    .result_o    (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign fired_o       = res_q.fired;
  assign click_count_o = res_q.click_count;

endmodule

// ----- src/mcd_core.sv -----
`timescale 1ns / 1ps

module mcd_core import mcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  mcd_event_t  event_i,
  input  logic [7:0]  tolerance_i,
  input  logic [15:0] window_i,
  output mcd_result_t result_o
);

  logic        counting_q, counting_d;
  logic [7:0]  clicks_q, clicks_d;
  logic [15:0] anchor_x_q, anchor_x_d;
  logic [15:0] anchor_y_q, anchor_y_d;
  logic [15:0] silence_q, silence_d;

  logic [15:0] diff_x, diff_y;
  logic        near;

  // per-axis distance to the anchor
  assign diff_x = (event_i.pos_x >= anchor_x_q) ? (event_i.pos_x - anchor_x_q)
                                                : (anchor_x_q - event_i.pos_x);
  assign diff_y = (event_i.pos_y >= anchor_y_q) ? (event_i.pos_y - anchor_y_q)
                                                : (anchor_y_q - event_i.pos_y);
  assign near = (diff_x <= {8'd0, tolerance_i}) && (diff_y <= {8'd0, tolerance_i});

  // event handling
  always_comb begin
    counting_d  = counting_q;
    clicks_d    = clicks_q;
    anchor_x_d  = anchor_x_q;
    anchor_y_d  = anchor_y_q;
    silence_d   = silence_q;
    result_o    = '0;
    unique case (mcd_op_e'(event_i.op))
      OP_PRESS: begin
        if (!counting_q) begin
          counting_d = 1'b1;
          clicks_d   = 8'd1;
          anchor_x_d = event_i.pos_x;
          anchor_y_d = event_i.pos_y;
          silence_d  = window_i;
        end else if (near) begin
          if (clicks_q != CLICKS_MAX) begin
            clicks_d = clicks_q + 8'd1;
          end
          silence_d = window_i;
        end else begin
          counting_d = 1'b0;
          clicks_d   = '0;
          silence_d  = '0;
        end
      end
      OP_MOTION: begin
        if (counting_q && !near) begin
          counting_d = 1'b0;
          clicks_d   = '0;
          silence_d  = '0;
        end
      end
      OP_TICK: begin
        if (counting_q) begin
          if (event_i.elapsed_ms >= silence_q) begin
            result_o.fired       = 1'b1;
            result_o.click_count = clicks_q;
            counting_d = 1'b0;
            clicks_d   = '0;
            silence_d  = '0;
          end else begin
            silence_d = silence_q - event_i.elapsed_ms;
          end
        end
      end
      // unused code leaves the state alone
      default: begin
      end
    endcase
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counting_q <= 1'b0;
      clicks_q   <= '0;
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      silence_q  <= '0;
    end else if (step_i) begin
      counting_q <= counting_d;
      clicks_q   <= clicks_d;
      anchor_x_q <= anchor_x_d;
      anchor_y_q <= anchor_y_d;
      silence_q  <= silence_d;
    end
  end

endmodule

// ----- src/mcd_checker.sv -----
`timescale 1ns / 1ps

module mcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       fired_o,
  input logic [7:0] click_count_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fired_o) && $stable(click_count_o))
    else $error("stalled result beat changed");

  // input is only held off while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result register free");

  // a quiet result carries no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fired_o |-> click_count_o == 8'd0)
    else $error("count without fire");

  // a reported sequence has at least one click
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> click_count_o != 8'd0)
    else $error("fired with zero clicks");

endmodule

bind multi_click_detector mcd_checker u_mcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .fired_o       (fired_o),
  .click_count_o (click_count_o)
);
